// File: design/wtr_pkg.sv
`timescale 1ns / 1ps
// wtr_pkg: shared widths, breakpoints, divider table and item types for wavelength_to_rgb
package wtr_pkg;

  // input format
  localparam int FRAC_BITS = 4;
  localparam int W_W       = 14;

  // breakpoints in 1/16 nm
  localparam logic [W_W-1:0] W_380 = W_W'(380 << FRAC_BITS);
  localparam logic [W_W-1:0] W_420 = W_W'(420 << FRAC_BITS);
  localparam logic [W_W-1:0] W_440 = W_W'(440 << FRAC_BITS);
  localparam logic [W_W-1:0] W_490 = W_W'(490 << FRAC_BITS);
  localparam logic [W_W-1:0] W_510 = W_W'(510 << FRAC_BITS);
  localparam logic [W_W-1:0] W_580 = W_W'(580 << FRAC_BITS);
  localparam logic [W_W-1:0] W_645 = W_W'(645 << FRAC_BITS);
  localparam logic [W_W-1:0] W_650 = W_W'(650 << FRAC_BITS);
  localparam logic [W_W-1:0] W_780 = W_W'(780 << FRAC_BITS);

  // width of the violet red hue ramp (60 nm) and of the product of the two violet ramps
  localparam int RISE_W  = $clog2((60 << FRAC_BITS) + 1);
  localparam int N_W     = 2 * RISE_W;
  localparam int D_W     = N_W;
  localparam int Q_W     = 8;
  localparam int X_W     = N_W + Q_W;
  localparam int SHIFT   = X_W;
  localparam int M_W     = X_W - $clog2(20 << FRAC_BITS) + 1;
  localparam int P_W     = X_W + M_W;

  // channel kinds
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] CH_ZERO  = 2'd0;
  localparam logic [MODE_W-1:0] CH_FULL  = 2'd1;
  localparam logic [MODE_W-1:0] CH_RATIO = 2'd2;

  // divider select codes, one per ramp
  localparam int DIV_W = 3;
  localparam logic [DIV_W-1:0] DIV_BLUE_RISE    = 3'd0;
  localparam logic [DIV_W-1:0] DIV_RED_RISE     = 3'd1;
  localparam logic [DIV_W-1:0] DIV_RED_VIOLET   = 3'd2;
  localparam logic [DIV_W-1:0] DIV_GREEN_BLUE   = 3'd3;
  localparam logic [DIV_W-1:0] DIV_BLUE_CYAN    = 3'd4;
  localparam logic [DIV_W-1:0] DIV_RED_GREEN    = 3'd5;
  localparam logic [DIV_W-1:0] DIV_GREEN_ORANGE = 3'd6;
  localparam logic [DIV_W-1:0] DIV_RED_FALL     = 3'd7;

  // ramp denominators
  localparam longint D_BLUE_RISE    = longint'(40) << FRAC_BITS;
  localparam longint D_RED_RISE     = (longint'(60) << FRAC_BITS) * (longint'(40) << FRAC_BITS);
  localparam longint D_RED_VIOLET   = longint'(60) << FRAC_BITS;
  localparam longint D_GREEN_BLUE   = longint'(50) << FRAC_BITS;
  localparam longint D_BLUE_CYAN    = longint'(20) << FRAC_BITS;
  localparam longint D_RED_GREEN    = longint'(70) << FRAC_BITS;
  localparam longint D_GREEN_ORANGE = longint'(65) << FRAC_BITS;
  localparam longint D_RED_FALL     = longint'(130) << FRAC_BITS;

  // reciprocals, floor(2^SHIFT / D)
  localparam longint ONE_S = longint'(1) << SHIFT;
  localparam longint R_BLUE_RISE    = ONE_S / D_BLUE_RISE;
  localparam longint R_RED_RISE     = ONE_S / D_RED_RISE;
  localparam longint R_RED_VIOLET   = ONE_S / D_RED_VIOLET;
  localparam longint R_GREEN_BLUE   = ONE_S / D_GREEN_BLUE;
  localparam longint R_BLUE_CYAN    = ONE_S / D_BLUE_CYAN;
  localparam longint R_RED_GREEN    = ONE_S / D_RED_GREEN;
  localparam longint R_GREEN_ORANGE = ONE_S / D_GREEN_ORANGE;
  localparam longint R_RED_FALL     = ONE_S / D_RED_FALL;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIV_W-1:0]  div;
    logic [N_W-1:0]    num;
  } chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } item_t;

  typedef struct packed {
    logic       chk_v;
    logic [2:0] quot_ok;
  } bk_stat_t;

  // denominator of a ramp
  function automatic logic [D_W-1:0] div_den(input logic [DIV_W-1:0] code);
    logic [D_W-1:0] d;
    unique case (code)
      DIV_BLUE_RISE:    d = D_W'(D_BLUE_RISE);
      DIV_RED_RISE:     d = D_W'(D_RED_RISE);
      DIV_RED_VIOLET:   d = D_W'(D_RED_VIOLET);
      DIV_GREEN_BLUE:   d = D_W'(D_GREEN_BLUE);
      DIV_BLUE_CYAN:    d = D_W'(D_BLUE_CYAN);
      DIV_RED_GREEN:    d = D_W'(D_RED_GREEN);
      DIV_GREEN_ORANGE: d = D_W'(D_GREEN_ORANGE);
      DIV_RED_FALL:     d = D_W'(D_RED_FALL);
    endcase
    return d;
  endfunction

  // reciprocal of a ramp denominator
  function automatic logic [M_W-1:0] div_rcp(input logic [DIV_W-1:0] code);
    logic [M_W-1:0] r;
    unique case (code)
      DIV_BLUE_RISE:    r = M_W'(R_BLUE_RISE);
      DIV_RED_RISE:     r = M_W'(R_RED_RISE);
      DIV_RED_VIOLET:   r = M_W'(R_RED_VIOLET);
      DIV_GREEN_BLUE:   r = M_W'(R_GREEN_BLUE);
      DIV_BLUE_CYAN:    r = M_W'(R_BLUE_CYAN);
      DIV_RED_GREEN:    r = M_W'(R_RED_GREEN);
      DIV_GREEN_ORANGE: r = M_W'(R_GREEN_ORANGE);
      DIV_RED_FALL:     r = M_W'(R_RED_FALL);
    endcase
    return r;
  endfunction

endpackage

// File: design/wtr_front.sv
`timescale 1ns / 1ps
// wtr_front: accepts wavelength beats and classifies them into per-channel ramp terms
module wtr_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [wtr_pkg::W_W-1:0]   in_wavelength_q4,
  output logic                      q_push,
  output wtr_pkg::item_t            q_item,
  input  logic                      q_full
);

  logic                         f_v_r;
  logic                         f_v_nxt;
  wtr_pkg::item_t               f_item_r;
  wtr_pkg::item_t               item_c;
  logic                         accept;
  logic [wtr_pkg::W_W-1:0]      w;
  logic [wtr_pkg::RISE_W-1:0]   rise_a;
  logic [wtr_pkg::RISE_W-1:0]   rise_b;
  logic [wtr_pkg::N_W-1:0]      rise_prod;

  // handshake: hold one classified beat until the queue takes it
  assign q_push  = f_v_r && !q_full;
  assign in_full = f_v_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_item  = f_item_r;
  assign w       = in_wavelength_q4;

  // violet red is the product of the hue ramp and the intensity ramp
  assign rise_a    = wtr_pkg::RISE_W'(wtr_pkg::W_440 - w);
  assign rise_b    = wtr_pkg::RISE_W'(w - wtr_pkg::W_380);
  assign rise_prod = wtr_pkg::N_W'(rise_a) * wtr_pkg::N_W'(rise_b);

  // segment classification
  always_comb begin
    item_c = '0;
    item_c.red.mode   = wtr_pkg::CH_ZERO;
    item_c.green.mode = wtr_pkg::CH_ZERO;
    item_c.blue.mode  = wtr_pkg::CH_ZERO;
    priority if (w < wtr_pkg::W_380 || w > wtr_pkg::W_780) begin
      // outside the span: black
    end else if (w < wtr_pkg::W_420) begin
      item_c.red.mode  = wtr_pkg::CH_RATIO;
      item_c.red.div   = wtr_pkg::DIV_RED_RISE;
      item_c.red.num   = rise_prod;
      item_c.blue.mode = wtr_pkg::CH_RATIO;
      item_c.blue.div  = wtr_pkg::DIV_BLUE_RISE;
      item_c.blue.num  = wtr_pkg::N_W'(w - wtr_pkg::W_380);
    end else if (w < wtr_pkg::W_440) begin
      item_c.red.mode  = wtr_pkg::CH_RATIO;
      item_c.red.div   = wtr_pkg::DIV_RED_VIOLET;
      item_c.red.num   = wtr_pkg::N_W'(wtr_pkg::W_440 - w);
      item_c.blue.mode = wtr_pkg::CH_FULL;
    end else if (w < wtr_pkg::W_490) begin
      item_c.green.mode = wtr_pkg::CH_RATIO;
      item_c.green.div  = wtr_pkg::DIV_GREEN_BLUE;
      item_c.green.num  = wtr_pkg::N_W'(w - wtr_pkg::W_440);
      item_c.blue.mode  = wtr_pkg::CH_FULL;
    end else if (w < wtr_pkg::W_510) begin
      item_c.green.mode = wtr_pkg::CH_FULL;
      item_c.blue.mode  = wtr_pkg::CH_RATIO;
      item_c.blue.div   = wtr_pkg::DIV_BLUE_CYAN;
      item_c.blue.num   = wtr_pkg::N_W'(wtr_pkg::W_510 - w);
    end else if (w < wtr_pkg::W_580) begin
      item_c.red.mode   = wtr_pkg::CH_RATIO;
      item_c.red.div    = wtr_pkg::DIV_RED_GREEN;
      item_c.red.num    = wtr_pkg::N_W'(w - wtr_pkg::W_510);
      item_c.green.mode = wtr_pkg::CH_FULL;
    end else if (w < wtr_pkg::W_645) begin
      item_c.red.mode   = wtr_pkg::CH_FULL;
      item_c.green.mode = wtr_pkg::CH_RATIO;
      item_c.green.div  = wtr_pkg::DIV_GREEN_ORANGE;
      item_c.green.num  = wtr_pkg::N_W'(wtr_pkg::W_645 - w);
    end else if (w <= wtr_pkg::W_650) begin
      item_c.red.mode = wtr_pkg::CH_FULL;
    end else begin
      item_c.red.mode = wtr_pkg::CH_RATIO;
      item_c.red.div  = wtr_pkg::DIV_RED_FALL;
      item_c.red.num  = wtr_pkg::N_W'(wtr_pkg::W_780 - w);
    end
  end

  // front stage valid
  always_comb begin
    priority if (accept) begin
      f_v_nxt = 1'b1;
    end else if (q_push) begin
      f_v_nxt = 1'b0;
    end else begin
      f_v_nxt = f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  // front stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= item_c;
    end
  end

endmodule

// File: design/wtr_queue.sv
`timescale 1ns / 1ps
// wtr_queue: short first-in first-out queue of classified beats between front and back
module wtr_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  wtr_pkg::item_t           wr_item,
  input  logic                     rd_en,
  output wtr_pkg::item_t           rd_item,
  output logic [wtr_pkg::QCW-1:0]  count
);

  wtr_pkg::item_t               mem_r [wtr_pkg::QDEPTH];
  logic [wtr_pkg::QAW-1:0]      wr_ptr_r;
  logic [wtr_pkg::QAW-1:0]      rd_ptr_r;
  logic [wtr_pkg::QCW-1:0]      cnt_r;
  logic [wtr_pkg::QCW-1:0]      cnt_nxt;

  assign rd_item = mem_r[rd_ptr_r];
  assign count   = cnt_r;

  // occupancy
  always_comb begin
    unique case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + wtr_pkg::QCW'(1);
      2'b01:   cnt_nxt = cnt_r - wtr_pkg::QCW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + wtr_pkg::QAW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + wtr_pkg::QAW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: design/wtr_back.sv
`timescale 1ns / 1ps
// wtr_back: three-stage reciprocal divider pipeline that turns ramp terms into 8-bit channels
module wtr_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  wtr_pkg::item_t           q_item,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue,
  output wtr_pkg::bk_stat_t        stat
);

  logic                            en;
  logic                            s1_v_r;
  logic                            s2_v_r;
  logic                            s3_v_r;
  logic                            s1_v_nxt;
  wtr_pkg::chan_t                  ch [3];

  logic [wtr_pkg::MODE_W-1:0]      s1_mode_r [3];
  logic [wtr_pkg::DIV_W-1:0]       s1_div_r  [3];
  logic [wtr_pkg::X_W-1:0]         s1_x_r    [3];
  logic [wtr_pkg::P_W-1:0]         s1_p_r    [3];
  logic [wtr_pkg::MODE_W-1:0]      s2_mode_r [3];
  logic [wtr_pkg::DIV_W-1:0]       s2_div_r  [3];
  logic [wtr_pkg::X_W-1:0]         s2_x_r    [3];
  logic [wtr_pkg::X_W-1:0]         s2_qd_r   [3];
  logic [wtr_pkg::Q_W-1:0]         s2_q_r    [3];
  logic [7:0]                      s3_val_r  [3];

  // one stall for the whole pipe; the last stage is the output register
  assign en        = !s3_v_r || out_pop;
  assign q_pop     = en && !q_empty;
  assign s1_v_nxt  = !q_empty;
  assign out_empty = !s3_v_r;
  assign out_red   = s3_val_r[0];
  assign out_green = s3_val_r[1];
  assign out_blue  = s3_val_r[2];
  assign stat.chk_v = s2_v_r;

  assign ch[0] = q_item.red;
  assign ch[1] = q_item.green;
  assign ch[2] = q_item.blue;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_chan
    logic [wtr_pkg::X_W-1:0] x_c;
    logic [wtr_pkg::Q_W-1:0] q_est;
    logic [wtr_pkg::D_W-1:0] den2;
    logic [wtr_pkg::X_W:0]   rem;
    logic [wtr_pkg::X_W:0]   den_x;
    logic [wtr_pkg::Q_W:0]   q_fix;
    logic [7:0]              val_c;

    // scale by 255 as shift and subtract
    assign x_c = (wtr_pkg::X_W'(ch[g].num) << 8) - wtr_pkg::X_W'(ch[g].num);

    // estimate from reciprocal, low by at most one
    assign q_est = s1_p_r[g][wtr_pkg::SHIFT +: wtr_pkg::Q_W];

    // remainder check and correction
    assign den2  = wtr_pkg::div_den(s2_div_r[g]);
    assign den_x = (wtr_pkg::X_W + 1)'(den2);
    assign rem   = {1'b0, s2_x_r[g]} - {1'b0, s2_qd_r[g]};
    assign q_fix = (rem >= den_x) ? ({1'b0, s2_q_r[g]} + (wtr_pkg::Q_W + 1)'(1))
                                  : {1'b0, s2_q_r[g]};
    assign stat.quot_ok[g] = !rem[wtr_pkg::X_W] && (rem < (den_x << 1));

    // channel result with cap
    always_comb begin
      unique case (s2_mode_r[g])
        wtr_pkg::CH_FULL:  val_c = 8'hFF;
        wtr_pkg::CH_RATIO: val_c = q_fix[wtr_pkg::Q_W] ? 8'hFF : q_fix[7:0];
        default:           val_c = 8'h00;
      endcase
    end

    // stage 1: scaled numerator times reciprocal
    // stage 2: estimate times denominator
    // stage 3: corrected quotient
    always_ff @(posedge clk) begin
      if (en) begin
        s1_mode_r[g] <= ch[g].mode;
        s1_div_r[g]  <= ch[g].div;
        s1_x_r[g]    <= x_c;
        s1_p_r[g]    <= wtr_pkg::P_W'(x_c) * wtr_pkg::P_W'(wtr_pkg::div_rcp(ch[g].div));
        s2_mode_r[g] <= s1_mode_r[g];
        s2_div_r[g]  <= s1_div_r[g];
        s2_x_r[g]    <= s1_x_r[g];
        s2_q_r[g]    <= q_est;
        s2_qd_r[g]   <= wtr_pkg::X_W'(wtr_pkg::X_W'(q_est)
                        * wtr_pkg::X_W'(wtr_pkg::div_den(s1_div_r[g])));
        s3_val_r[g]  <= val_c;
      end
    end
  end

endmodule

// File: design/wavelength_to_rgb.sv
`timescale 1ns / 1ps
// wavelength_to_rgb: wavelength to 8-bit color converter, queue-style ports on both sides
//
// Input channel: drive in_wavelength_q4 (nm, four fraction bits) with in_push; a beat is
// taken on a rising edge with in_push high and in_full low.
// Result channel: while out_empty is low, out_red, out_green and out_blue hold the oldest
// color; it is taken on a rising edge with out_pop high. One color per wavelength, in order.
// Path: a beat passes the front register, the queue, then the three stages of the reciprocal
// divider before it is shown.
// Throughput: one beat per cycle unless stalled; each channel has its own 28x20 multiplier
// in the first divider stage and an 8x20 multiplier in the second, each used once per beat.
// Stall: when out_pop stays low the divider pipe freezes with the color held; the front
// keeps taking beats into a four-deep queue and raises in_full once it and its register
// are full.
// Reset: synchronous, active-low rst_n empties front, queue and pipe; out_empty is high and
// in_full low on the first cycle after reset. No other state is kept.
module wavelength_to_rgb (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [wtr_pkg::W_W-1:0]  in_wavelength_q4,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue
);

  logic                        q_push;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  logic [wtr_pkg::QCW-1:0]     q_count;
  wtr_pkg::item_t              q_wr_item;
  wtr_pkg::item_t              q_rd_item;
  wtr_pkg::bk_stat_t           bk_stat;

  // queue flags
  assign q_full  = (q_count == wtr_pkg::QCW'(wtr_pkg::QDEPTH));
  assign q_empty = (q_count == '0);

  // accept and classify
  wtr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_wavelength_q4 (in_wavelength_q4),
    .q_push           (q_push),
    .q_item           (q_wr_item),
    .q_full           (q_full)
  );

  // decoupling queue
  wtr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .count   (q_count)
  );

  // divide and deliver
  wtr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_rd_item),
    .out_empty (out_empty),
    .out_pop   (out_pop && !out_empty),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .stat      (bk_stat)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= wtr_pkg::QCW'(wtr_pkg::QDEPTH))
    else $error("queue occupancy beyond depth");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("not empty after reset");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.chk_v |-> (&bk_stat.quot_ok))
    else $error("reciprocal estimate off by more than one");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");
`endif

endmodule
